/* hw/rtl/gbpf_pkg.sv */
// ----------------------------------------------------------------------------
// gbpf_pkg
// Shared constants, command/status bundles and helpers for the grid path
// finder (controller and datapath).
// ----------------------------------------------------------------------------
package gbpf_pkg;

    // Grid and queue geometry
    localparam int GRID_W      = 8;
    localparam int GRID_H      = 8;
    localparam int QUEUE_DEPTH = 128;
    localparam int CELL_COUNT  = GRID_W * GRID_H;
    localparam int MAX_RESULTS = 63;

    // Port coordinate width and internal widths
    localparam int POS_W = 3;
    localparam int XW    = ($clog2(GRID_W) > POS_W) ? $clog2(GRID_W) : POS_W;
    localparam int YW    = ($clog2(GRID_H) > POS_W) ? $clog2(GRID_H) : POS_W;
    localparam int CW    = $clog2(CELL_COUNT);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int NW    = $clog2(QUEUE_DEPTH + 1);
    localparam int KW    = $clog2(MAX_RESULTS + 1);

    // Read address select for the open and seen maps
    localparam logic [1:0] ADDR_SRC = 2'd0;
    localparam logic [1:0] ADDR_DST = 2'd1;
    localparam logic [1:0] ADDR_NB  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;       // input transaction accepted
        logic       clr;        // clear one seen entry, advance sweep
        logic [1:0] rd_sel;     // map read address select
        logic       src_cap;    // capture start square open bit
        logic       seed;       // mark start seen and queue it
        logic       pop;        // read queue head and advance
        logic       cur_load;   // load current square from queue
        logic       dir_next;   // advance neighbor direction
        logic       discover;   // mark neighbor seen, record parent, enqueue
        logic       tr_start;   // begin trace at the target
        logic       tr_emit;    // emit a path step and step back
        logic       emit_none;  // emit the not-found result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic start_ok;
        logic q_empty;
        logic cur_is_dst;
        logic nb_on_grid;
        logic nb_free;
        logic dir_last;
        logic dst_seen;
        logic out_free;
        logic tr_last;
    } t_sts;

    // Linear cell index of a square
    function automatic logic [CW-1:0] cell_idx(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
        logic [CW-1:0] xc;
        logic [CW-1:0] yc;
        xc = CW'(x);
        yc = CW'(y);
        return CW'(yc * CW'(GRID_W)) + xc;
    endfunction

endpackage

/* hw/rtl/gbpf_ctrl.sv */
// ----------------------------------------------------------------------------
// gbpf_ctrl
// Sequencer for the path finder: takes input transactions, sweeps the seen
// map, runs the breadth-first search and the trace back, and issues one
// command set per cycle to the datapath.
// ----------------------------------------------------------------------------
module gbpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    output logic          o_in_stall,
    input  gbpf_pkg::t_sts i_sts,
    output gbpf_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_RD_SRC  = 4'd2;
    localparam logic [3:0] S_RD_DST  = 4'd3;
    localparam logic [3:0] S_EVAL    = 4'd4;
    localparam logic [3:0] S_POP     = 4'd5;
    localparam logic [3:0] S_CUR     = 4'd6;
    localparam logic [3:0] S_NB      = 4'd7;
    localparam logic [3:0] S_NCHK    = 4'd8;
    localparam logic [3:0] S_TEST_RD = 4'd9;
    localparam logic [3:0] S_TEST    = 4'd10;
    localparam logic [3:0] S_TR_RD   = 4'd11;
    localparam logic [3:0] S_TR_OUT  = 4'd12;
    localparam logic [3:0] S_NONE    = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Decode next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_action) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_RD_SRC;
                end
            end
            S_RD_SRC: begin
                o_cmd.rd_sel = gbpf_pkg::ADDR_SRC;
                n_state      = S_RD_DST;
            end
            S_RD_DST: begin
                o_cmd.rd_sel  = gbpf_pkg::ADDR_DST;
                o_cmd.src_cap = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.rd_sel = gbpf_pkg::ADDR_DST;
                if (i_sts.start_ok) begin
                    o_cmd.seed = 1'b1;
                    n_state    = S_POP;
                end else begin
                    n_state = S_NONE;
                end
            end
            S_POP: begin
                if (i_sts.q_empty) begin
                    n_state = S_TEST_RD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_CUR;
                end
            end
            S_CUR: begin
                o_cmd.cur_load = 1'b1;
                n_state = i_sts.cur_is_dst ? S_TR_RD : S_NB;
            end
            S_NB: begin
                o_cmd.rd_sel = gbpf_pkg::ADDR_NB;
                if (i_sts.nb_on_grid) begin
                    n_state = S_NCHK;
                end else if (i_sts.dir_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.dir_next = 1'b1;
                end
            end
            S_NCHK: begin
                o_cmd.rd_sel   = gbpf_pkg::ADDR_NB;
                o_cmd.discover = i_sts.nb_free;
                if (i_sts.dir_last) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.dir_next = 1'b1;
                    n_state        = S_NB;
                end
            end
            S_TEST_RD: begin
                o_cmd.rd_sel = gbpf_pkg::ADDR_DST;
                n_state      = S_TEST;
            end
            S_TEST: begin
                o_cmd.rd_sel = gbpf_pkg::ADDR_DST;
                if (i_sts.dst_seen) begin
                    o_cmd.tr_start = 1'b1;
                    n_state        = S_TR_RD;
                end else begin
                    n_state = S_NONE;
                end
            end
            S_TR_RD: begin
                n_state = S_TR_OUT;
            end
            S_TR_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.tr_emit = 1'b1;
                    n_state = i_sts.tr_last ? S_IDLE : S_TR_RD;
                end
            end
            S_NONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A query always starts with the seen-map sweep
    a_query_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_action) |=> (r_state == S_CLEAR))
        else $error("query did not start with the seen-map sweep");

    // The final path step returns the engine to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.tr_emit && i_sts.tr_last) |=> (r_state == S_IDLE))
        else $error("engine busy after final path step");

    // A seed, issued only on a successful start check, leads to the queue pop
    a_seed_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.seed |=> (r_state == S_POP))
        else $error("seed not followed by a queue pop");

endmodule

/* hw/rtl/gbpf_dpath.sv */
// ----------------------------------------------------------------------------
// gbpf_dpath
// Datapath of the path finder: open map, seen map, parent directions, search
// queue, square registers and the result output register.
// ----------------------------------------------------------------------------
module gbpf_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbpf_pkg::t_cmd                  i_cmd,
    output gbpf_pkg::t_sts                  o_sts,
    input  logic                            i_action,
    input  logic [gbpf_pkg::POS_W-1:0]      i_pos_x,
    input  logic [gbpf_pkg::POS_W-1:0]      i_pos_y,
    input  logic                            i_open_square,
    input  logic [gbpf_pkg::POS_W-1:0]      i_goal_x,
    input  logic [gbpf_pkg::POS_W-1:0]      i_goal_y,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [gbpf_pkg::POS_W-1:0]      o_step_x,
    output logic [gbpf_pkg::POS_W-1:0]      o_step_y,
    output logic                            o_found,
    output logic                            o_last
);

    localparam int XW = gbpf_pkg::XW;
    localparam int YW = gbpf_pkg::YW;
    localparam int CW = gbpf_pkg::CW;
    localparam int QW = gbpf_pkg::QW;
    localparam int NW = gbpf_pkg::NW;
    localparam int KW = gbpf_pkg::KW;
    localparam int NCELL = gbpf_pkg::CELL_COUNT;
    localparam int QDEPTH = gbpf_pkg::QUEUE_DEPTH;

    // Neighbor directions, in search order
    localparam logic [1:0] DIR_PX = 2'd0;
    localparam logic [1:0] DIR_NX = 2'd1;
    localparam logic [1:0] DIR_PY = 2'd2;
    localparam logic [1:0] DIR_NY = 2'd3;

    // Query and walk registers
    logic [XW-1:0] r_src_x, r_dst_x, r_cur_x;
    logic [YW-1:0] r_src_y, r_dst_y, r_cur_y;
    logic [1:0]    r_dir;
    logic [CW-1:0] r_clr_cnt;
    logic          r_src_open;
    logic [KW-1:0] r_k;

    // Queue pointers
    logic [QW-1:0] r_q_head;
    logic [QW-1:0] r_q_tail;
    logic [NW-1:0] r_q_count;

    // Memories and registered read data
    logic             r_open_mem [NCELL];
    logic [NCELL-1:0] r_open_vld;
    logic             r_open_rd;
    logic             r_seen_mem [NCELL];
    logic             r_seen_rd;
    logic [1:0]       r_par_mem [NCELL];
    logic [1:0]       r_par_rd;
    logic [XW+YW-1:0] r_q_mem [QDEPTH];
    logic [XW+YW-1:0] r_q_rd;

    // Output register
    logic          r_out_valid;
    logic [XW-1:0] r_out_x;
    logic [YW-1:0] r_out_y;
    logic          r_out_found;
    logic          r_out_last;

    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic          nb_on_grid;
    logic [XW-1:0] prev_x;
    logic [YW-1:0] prev_y;
    logic [CW-1:0] src_cell, dst_cell, cur_cell, nb_cell, rd_cell, wr_cell;
    logic [XW-1:0] in_x;
    logic [YW-1:0] in_y;
    logic          in_on_grid;
    logic          query_on_grid;
    logic          out_free;
    logic          q_full;
    logic          enq;

    // Neighbor square of the current square
    always_comb begin
        nb_x       = r_cur_x;
        nb_y       = r_cur_y;
        nb_on_grid = 1'b1;
        case (r_dir)
            DIR_PX: begin
                nb_x       = r_cur_x + XW'(1);
                nb_on_grid = (r_cur_x != XW'(gbpf_pkg::GRID_W - 1));
            end
            DIR_NX: begin
                nb_x       = r_cur_x - XW'(1);
                nb_on_grid = (r_cur_x != '0);
            end
            DIR_PY: begin
                nb_y       = r_cur_y + YW'(1);
                nb_on_grid = (r_cur_y != YW'(gbpf_pkg::GRID_H - 1));
            end
            default: begin
                nb_y       = r_cur_y - YW'(1);
                nb_on_grid = (r_cur_y != '0);
            end
        endcase
    end

    // Parent square of the current square, undoing its discovery step
    always_comb begin
        prev_x = r_cur_x;
        prev_y = r_cur_y;
        case (r_par_rd)
            DIR_PX:  prev_x = r_cur_x - XW'(1);
            DIR_NX:  prev_x = r_cur_x + XW'(1);
            DIR_PY:  prev_y = r_cur_y - YW'(1);
            default: prev_y = r_cur_y + YW'(1);
        endcase
    end

    // Cell indexes and map read address
    always_comb begin
        in_x          = XW'(i_pos_x);
        in_y          = YW'(i_pos_y);
        in_on_grid    = (32'(i_pos_x) < gbpf_pkg::GRID_W) &&
                        (32'(i_pos_y) < gbpf_pkg::GRID_H);
        wr_cell       = gbpf_pkg::cell_idx(in_x, in_y);
        src_cell      = gbpf_pkg::cell_idx(r_src_x, r_src_y);
        dst_cell      = gbpf_pkg::cell_idx(r_dst_x, r_dst_y);
        cur_cell      = gbpf_pkg::cell_idx(r_cur_x, r_cur_y);
        nb_cell       = gbpf_pkg::cell_idx(nb_x, nb_y);
        query_on_grid = (32'(r_src_x) < gbpf_pkg::GRID_W) &&
                        (32'(r_src_y) < gbpf_pkg::GRID_H) &&
                        (32'(r_dst_x) < gbpf_pkg::GRID_W) &&
                        (32'(r_dst_y) < gbpf_pkg::GRID_H);
        case (i_cmd.rd_sel)
            gbpf_pkg::ADDR_SRC: rd_cell = src_cell;
            gbpf_pkg::ADDR_DST: rd_cell = dst_cell;
            default:            rd_cell = nb_cell;
        endcase
        out_free = !r_out_valid || !i_out_stall;
        q_full   = (r_q_count == NW'(QDEPTH));
        enq      = i_cmd.discover && !q_full;
    end

    // Status to the controller
    always_comb begin
        o_sts.clr_last   = (r_clr_cnt == CW'(NCELL - 1));
        o_sts.start_ok   = query_on_grid && r_src_open && r_open_rd &&
                           (src_cell != dst_cell);
        o_sts.q_empty    = (r_q_count == '0);
        o_sts.cur_is_dst = (r_q_rd == {r_dst_y, r_dst_x});
        o_sts.nb_on_grid = nb_on_grid;
        o_sts.nb_free    = r_open_rd && !r_seen_rd;
        o_sts.dir_last   = (r_dir == DIR_NY);
        o_sts.dst_seen   = r_seen_rd;
        o_sts.out_free   = out_free;
        o_sts.tr_last    = ((prev_x == r_src_x) && (prev_y == r_src_y)) ||
                           (r_k == KW'(gbpf_pkg::MAX_RESULTS - 1));
    end

    // Open map: valid bits clear at reset, so unwritten squares read blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_vld <= '0;
        end else if (i_cmd.take && !i_action && in_on_grid) begin
            r_open_vld[wr_cell] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !i_action && in_on_grid) begin
            r_open_mem[wr_cell] <= i_open_square;
        end
        r_open_rd <= r_open_vld[rd_cell] && r_open_mem[rd_cell];
    end

    // Seen map: swept clear at each query, set on seed and discovery
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_seen_mem[r_clr_cnt] <= 1'b0;
        end else if (i_cmd.seed) begin
            r_seen_mem[src_cell] <= 1'b1;
        end else if (i_cmd.discover) begin
            r_seen_mem[nb_cell] <= 1'b1;
        end
        r_seen_rd <= r_seen_mem[rd_cell];
    end

    // Parent directions, read at the current square
    always_ff @(posedge i_clk) begin
        if (i_cmd.discover) begin
            r_par_mem[nb_cell] <= r_dir;
        end
        r_par_rd <= r_par_mem[cur_cell];
    end

    // Search queue storage, read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed) begin
            r_q_mem[r_q_tail] <= {r_src_y, r_src_x};
        end else if (enq) begin
            r_q_mem[r_q_tail] <= {nb_y, nb_x};
        end
        r_q_rd <= r_q_mem[r_q_head];
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head  <= '0;
            r_q_tail  <= '0;
            r_q_count <= '0;
        end else if (i_cmd.take) begin
            r_q_head  <= '0;
            r_q_tail  <= '0;
            r_q_count <= '0;
        end else if (i_cmd.seed) begin
            r_q_tail  <= (r_q_tail == QW'(QDEPTH - 1)) ? '0 : r_q_tail + QW'(1);
            r_q_count <= NW'(1);
        end else if (i_cmd.pop) begin
            r_q_head  <= (r_q_head == QW'(QDEPTH - 1)) ? '0 : r_q_head + QW'(1);
            r_q_count <= r_q_count - NW'(1);
        end else if (enq) begin
            r_q_tail  <= (r_q_tail == QW'(QDEPTH - 1)) ? '0 : r_q_tail + QW'(1);
            r_q_count <= r_q_count + NW'(1);
        end
    end

    // Query, sweep and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_src_x   <= in_x;
            r_src_y   <= in_y;
            r_dst_x   <= XW'(i_goal_x);
            r_dst_y   <= YW'(i_goal_y);
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + CW'(1);
        end
        if (i_cmd.src_cap) begin
            r_src_open <= r_open_rd;
        end
        if (i_cmd.cur_load) begin
            r_cur_x <= r_q_rd[XW-1:0];
            r_cur_y <= r_q_rd[XW+YW-1:XW];
            r_dir   <= DIR_PX;
            r_k     <= '0;
        end else if (i_cmd.tr_start) begin
            r_cur_x <= r_dst_x;
            r_cur_y <= r_dst_y;
            r_k     <= '0;
        end else if (i_cmd.tr_emit) begin
            r_cur_x <= prev_x;
            r_cur_y <= prev_y;
            r_k     <= r_k + KW'(1);
        end else if (i_cmd.dir_next) begin
            r_dir <= r_dir + 2'd1;
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.tr_emit || i_cmd.emit_none) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tr_emit) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_found <= 1'b1;
            r_out_last  <= o_sts.tr_last;
        end else if (i_cmd.emit_none) begin
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step_x    = r_out_x[gbpf_pkg::POS_W-1:0];
    assign o_step_y    = r_out_y[gbpf_pkg::POS_W-1:0];
    assign o_found     = r_out_found;
    assign o_last      = r_out_last;

    // Queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_q_count) <= QDEPTH)
        else $error("search queue count beyond depth");

    // No pop from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_q_count != '0))
        else $error("pop from empty search queue");

    // A result never overwrites one that is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tr_emit || i_cmd.emit_none) |-> !(r_out_valid && i_out_stall))
        else $error("result register overrun");

    // Discovery only for an on-grid neighbor
    a_disc_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.discover |-> nb_on_grid)
        else $error("discovery of an off-grid square");

endmodule

/* hw/rtl/grid_bfs_path_finder.sv */
// ----------------------------------------------------------------------------
// grid_bfs_path_finder
// Lee-style shortest path finder on an 8x8 map of open and blocked squares:
// write transactions edit the map, query transactions return the path from
// the target back toward the start.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        to block   i_in_valid / o_in_stall   action, pos_x/y, open_square,
//                                                 goal_x/y
//  out       from block o_out_valid / i_out_stall step_x/y, found, last
//
//  A query runs the seen-map sweep and the start checks, then a pop and
//  neighbor checks per queued square on the single-port maps, then one
//  parent read per path step. Reset is synchronous; the open map reads
//  all blocked right after reset. o_in_stall is high for the whole of a
//  query; i_out_stall holds the engine at the pending path step.
// ----------------------------------------------------------------------------
module grid_bfs_path_finder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [gbpf_pkg::POS_W-1:0] i_pos_x,
    input  logic [gbpf_pkg::POS_W-1:0] i_pos_y,
    input  logic                       i_open_square,
    input  logic [gbpf_pkg::POS_W-1:0] i_goal_x,
    input  logic [gbpf_pkg::POS_W-1:0] i_goal_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [gbpf_pkg::POS_W-1:0] o_step_x,
    output logic [gbpf_pkg::POS_W-1:0] o_step_y,
    output logic                       o_found,
    output logic                       o_last
);

    gbpf_pkg::t_cmd cmd;
    gbpf_pkg::t_sts sts;

    // Sequencer
    gbpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Maps, queue and result register
    gbpf_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_open_square (i_open_square),
        .i_goal_x      (i_goal_x),
        .i_goal_y      (i_goal_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_step_x      (o_step_x),
        .o_step_y      (o_step_y),
        .o_found       (o_found),
        .o_last        (o_last)
    );

endmodule

/* bench/grid_bfs_path_finder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bfs_path_finder_tb
// Self-checking bench for the grid path finder. Map writes and path queries
// are driven in random bursts. A scoreboard keeps its own copy of the map,
// runs a breadth-first search (+x, -x, +y, -y) on every accepted query and
// checks each returned path step field by field, while the result side
// stalls on patterns of its own.
// ----------------------------------------------------------------------------
module grid_bfs_path_finder_tb;

    localparam int GRID_X         = 8;
    localparam int GRID_Y         = 8;
    localparam int CELLS          = GRID_X * GRID_Y;
    localparam int PATH_MAX       = 63;
    localparam int TOTAL_ITEMS    = 270;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int MAX_REPORTS    = 40;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [gbpf_pkg::POS_W-1:0] t_coord;

    typedef enum logic [1:0] {
        DIR_POS_X,
        DIR_NEG_X,
        DIR_POS_Y,
        DIR_NEG_Y
    } t_dir;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   found;
        logic   last;
    } t_path_step;

    // ------------------------------------------------------------------------
    // Scoreboard: map copy, path search and expected step queue
    // ------------------------------------------------------------------------
    class path_scoreboard;
        bit         open_sq [CELLS];
        t_path_step expected_steps [$];
        int         n_err;
        int         n_writes;
        int         n_queries;
        int         n_paths;
        int         n_none;
        int         longest;

        function int dx_of(t_dir d);
            case (d)
                DIR_POS_X: return 1;
                DIR_NEG_X: return -1;
                default:   return 0;
            endcase
        endfunction

        function int dy_of(t_dir d);
            case (d)
                DIR_POS_Y: return 1;
                DIR_NEG_Y: return -1;
                default:   return 0;
            endcase
        endfunction

        // Update the map on a write; search and queue the path on a query
        function void note_input(logic act, t_coord px, t_coord py, logic op,
                                 t_coord gx, t_coord gy);
            int         src;
            int         dst;
            int         cur;
            int         cx;
            int         cy;
            int         nx;
            int         ny;
            int         nb;
            bit         seen [CELLS];
            t_dir       came_by [CELLS];
            int         frontier [$];
            t_path_step trace [$];
            t_path_step stp;

            src = int'(py) * GRID_X + int'(px);
            dst = int'(gy) * GRID_X + int'(gx);
            if (act == ACT_WRITE) begin
                open_sq[src] = op;
                n_writes++;
                return;
            end
            n_queries++;

            // Flood outward from the start until the target is dequeued
            if (open_sq[src] && open_sq[dst] && src != dst) begin
                seen[src] = 1'b1;
                frontier  = {frontier, src};
                while (frontier.size() > 0) begin
                    cur = frontier.pop_front();
                    if (cur == dst) break;
                    cx = cur % GRID_X;
                    cy = cur / GRID_X;
                    for (int d = 0; d < 4; d++) begin
                        nx = cx + dx_of(t_dir'(d));
                        ny = cy + dy_of(t_dir'(d));
                        if (nx < 0 || nx >= GRID_X || ny < 0 || ny >= GRID_Y) continue;
                        nb = ny * GRID_X + nx;
                        if (!open_sq[nb] || seen[nb]) continue;
                        seen[nb]    = 1'b1;
                        came_by[nb] = t_dir'(d);
                        frontier    = {frontier, nb};
                    end
                end
            end

            // Walk back from the target, leaving the start out
            if (seen[dst] && src != dst) begin
                cur = dst;
                while (cur != src && trace.size() < PATH_MAX) begin
                    cx        = cur % GRID_X;
                    cy        = cur / GRID_X;
                    stp.x     = t_coord'(cx);
                    stp.y     = t_coord'(cy);
                    stp.found = 1'b1;
                    stp.last  = 1'b0;
                    trace     = {trace, stp};
                    cx  = cx - dx_of(came_by[cur]);
                    cy  = cy - dy_of(came_by[cur]);
                    cur = cy * GRID_X + cx;
                end
                trace[trace.size() - 1].last = 1'b1;
                n_paths++;
                if (trace.size() > longest) longest = trace.size();
            end else begin
                stp   = '{x: '0, y: '0, found: 1'b0, last: 1'b1};
                trace = {trace, stp};
                n_none++;
            end
            foreach (trace[i]) expected_steps = {expected_steps, trace[i]};
        endfunction

        function void report(string field, int exp_v, int act_v);
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("ERROR %0t: %s expected %0d got %0d", $time, field, exp_v, act_v);
        endfunction

        // Compare one returned step with the oldest expectation
        function void check_result(t_coord x, t_coord y, logic found, logic last);
            t_path_step want;

            if (expected_steps.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("ERROR %0t: unexpected result x=%0d y=%0d found=%0b last=%0b",
                             $time, x, y, found, last);
                return;
            end
            want = expected_steps.pop_front();
            if (x !== want.x)         report("step_x", want.x, x);
            if (y !== want.y)         report("step_y", want.y, y);
            if (found !== want.found) report("found", want.found, found);
            if (last !== want.last)   report("last", want.last, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and shared state
    // ------------------------------------------------------------------------
    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    logic   i_action;
    t_coord i_pos_x;
    t_coord i_pos_y;
    logic   i_open_square;
    t_coord i_goal_x;
    t_coord i_goal_y;
    logic   o_out_valid;
    logic   i_out_stall;
    t_coord o_step_x;
    t_coord o_step_y;
    logic   o_found;
    logic   o_last;

    path_scoreboard sb;
    int             items_sent;
    int             burst_left;
    int             results_seen;
    int             hold_left;
    bit             pressure_done;
    int             mode_left;
    t_stall_mode    stall_mode;
    int             quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    grid_bfs_path_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_open_square (i_open_square),
        .i_goal_x      (i_goal_x),
        .i_goal_y      (i_goal_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_step_x      (o_step_x),
        .o_step_y      (o_step_y),
        .o_found       (o_found),
        .o_last        (o_last)
    );

    // ------------------------------------------------------------------------
    // Input side: offer one transaction, wait for it, then pace the burst
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input t_coord px, input t_coord py,
                             input logic op, input t_coord gx, input t_coord gy);
        int gap;

        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_open_square <= op;
        i_goal_x      <= gx;
        i_goal_y      <= gy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(act, px, py, op, gx, gy);
        items_sent++;

        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Pick an open square when one turns up within a few tries
    task automatic pick_open(output t_coord x, output t_coord y);
        int tries;

        tries = 0;
        do begin
            x = t_coord'($urandom_range(0, GRID_X - 1));
            y = t_coord'($urandom_range(0, GRID_Y - 1));
            tries++;
        end while (!sb.open_sq[int'(y) * GRID_X + int'(x)] && tries < 16);
    endtask

    task automatic rand_query();
        t_coord sx;
        t_coord sy;
        t_coord tx;
        t_coord ty;

        if ($urandom_range(0, 3) != 0) begin
            pick_open(sx, sy);
            pick_open(tx, ty);
        end else begin
            sx = t_coord'($urandom);
            sy = t_coord'($urandom);
            tx = t_coord'($urandom);
            ty = t_coord'($urandom);
        end
        send_item(ACT_QUERY, sx, sy, 1'($urandom), tx, ty);
    endtask

    // Serpentine maze: walls on odd rows with a gap at alternating ends
    task automatic build_maze();
        int   flip;
        int   gap_x;
        logic op;

        flip = $urandom_range(0, 1);
        for (int y = 0; y < GRID_Y; y++) begin
            gap_x = (((y / 2) % 2) == flip) ? GRID_X - 1 : 0;
            for (int x = 0; x < GRID_X; x++) begin
                op = !((y % 2 == 1) && (y < GRID_Y - 1)) || (x == gap_x);
                send_item(ACT_WRITE, t_coord'(x), t_coord'(y), op,
                          t_coord'($urandom), t_coord'($urandom));
            end
        end
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b1, 3'd0, 3'd7);
        send_item(ACT_QUERY, 3'd7, 3'd7, 1'b0, 3'd7, 3'd0);
        send_item(ACT_QUERY, 3'd0, 3'd7, 1'b1, 3'd7, 3'd0);
        rand_query();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb            = new;
        items_sent    = 0;
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_WRITE;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_open_square <= 1'b0;
        i_goal_x      <= '0;
        i_goal_y      <= '0;
        i_out_stall   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: blocked start, blocked target, same square, tie order,
        // unreachable target, one-step path, reblocking a square
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b1, 3'd7, 3'd7);
        send_item(ACT_WRITE, 3'd0, 3'd0, 1'b1, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b0, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b1, 3'd0, 3'd0);
        send_item(ACT_WRITE, 3'd1, 3'd0, 1'b1, 3'd0, 3'd0);
        send_item(ACT_WRITE, 3'd0, 3'd1, 1'b1, 3'd0, 3'd0);
        send_item(ACT_WRITE, 3'd1, 3'd1, 1'b1, 3'd0, 3'd0);
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b0, 3'd1, 3'd1);
        send_item(ACT_QUERY, 3'd1, 3'd1, 1'b0, 3'd0, 3'd0);
        send_item(ACT_WRITE, 3'd7, 3'd7, 1'b1, 3'd0, 3'd0);
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b1, 3'd7, 3'd7);
        send_item(ACT_WRITE, 3'd1, 3'd0, 1'b0, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd0, 3'd0, 1'b0, 3'd1, 3'd1);
        send_item(ACT_WRITE, 3'd7, 3'd6, 1'b1, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd7, 3'd6, 1'b1, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd3, 3'd3, 1'b0, 3'd7, 3'd6);
        send_item(ACT_WRITE, 3'd7, 3'd7, 1'b0, 3'd7, 3'd7);
        send_item(ACT_QUERY, 3'd7, 3'd7, 1'b1, 3'd7, 3'd6);

        // Random: one long maze, then a mix of edits and queries
        build_maze();
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 99) < 35) begin
                rand_query();
            end else begin
                send_item(ACT_WRITE, t_coord'($urandom), t_coord'($urandom),
                          ($urandom_range(0, 99) < 80), t_coord'($urandom),
                          t_coord'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding steps, then let any trailing result show up
        while (sb.expected_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d map writes and %0d queries: %0d paths (longest %0d steps)",
                 sb.n_writes, sb.n_queries, sb.n_paths, sb.longest);
        $display("%0d not-found results, %0d steps checked, %0d errors",
                 sb.n_none, results_seen, sb.n_err);
        if (sb.n_err == 0) begin
            $display("grid_bfs_path_finder: match");
        end else begin
            $display("grid_bfs_path_finder: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each transaction, then pick the next stall value
    // ------------------------------------------------------------------------
    initial begin
        results_seen  = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        mode_left     = 0;
        stall_mode    = STALL_NONE;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_step_x, o_step_y, o_found, o_last);
            results_seen++;
        end

        // Hold off once for a long stretch while a result is waiting
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!pressure_done && results_seen >= 12 && o_out_valid) begin
            pressure_done = 1'b1;
            hold_left     = HOLD_OFF_CYCLES;
            i_out_stall   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: abort when no transaction moves for too long
    // ------------------------------------------------------------------------
    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles at %0t", quiet_cycles, $time);
            $display("grid_bfs_path_finder: mismatch");
            $finish;
        end
    end

endmodule

/* files.f */
hw/rtl/gbpf_pkg.sv
hw/rtl/gbpf_ctrl.sv
hw/rtl/gbpf_dpath.sv
hw/rtl/grid_bfs_path_finder.sv
bench/grid_bfs_path_finder_tb.sv
